/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Each assumes clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/salfu_pkg.sv */
`timescale 1ns / 1ps

package salfu_pkg;

  // Field and register widths
  localparam int ADDR_W     = 32;
  localparam int BLK_W      = 13;
  localparam int SETS_W     = 7;
  localparam int WAYS_W     = 4;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int STEP_W     = 5;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_BLOCK_BYTES = 2'd0;
  localparam logic [1:0] REG_SET_COUNT   = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

  // Register reset values
  localparam logic [BLK_W-1:0]  BLOCK_BYTES_RST = 13'd16;
  localparam logic [SETS_W-1:0] SET_COUNT_RST   = 7'd64;
  localparam logic [WAYS_W-1:0] WAYS_IN_USE_RST = 4'd4;

endpackage

/* hw/rtl/salfu_ifs.sv */
`timescale 1ns / 1ps

interface salfu_req_if;
  logic                       valid;
  logic                       ready;
  logic [salfu_pkg::ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface salfu_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink (input valid, input hit, output ready);
endinterface

/* hw/rtl/set_assoc_cache_lookup_lfu_top.sv */
`timescale 1ns / 1ps
// Flow: a request passes through two 32-step divisions, one memory read per way
//   (each line is checked after its read) and a write-back of the chosen line.
// Requests are handled one at a time: the serial divider is shared by both divisions
//   and a request is taken only in idle, also while a result waits.
// Reset: clears control state, then sweeps all MAX_SETS * MAX_WAYS lines of the
//   line memory, marking them invalid with zero counts before taking requests.
`include "assert_macros.svh"

module set_assoc_cache_lookup_lfu_top #(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [salfu_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [salfu_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [salfu_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready,
  salfu_req_if.sink                         req,
  salfu_rsp_if.source                       rsp
);

  localparam int LINES = MAX_SETS * MAX_WAYS;
  localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int SW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int EW    = 1 + salfu_pkg::ADDR_W + COUNT_BITS;
  localparam int AW    = salfu_pkg::ADDR_W;
  localparam int BW    = salfu_pkg::BLK_W;
  localparam int WW    = salfu_pkg::WAYS_W;
  localparam int WC    = (MAX_WAYS + 1 > 16) ? $clog2(MAX_WAYS + 1) : salfu_pkg::WAYS_W;
  localparam int STW   = salfu_pkg::STEP_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV1  = 3'd2;
  localparam logic [2:0] ST_DIV2  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  // Configuration registers
  logic [BW-1:0]                 block_bytes;
  logic [salfu_pkg::SETS_W-1:0]  set_count;
  logic [WW-1:0]                 ways_in_use;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= salfu_pkg::BLOCK_BYTES_RST;
      set_count   <= salfu_pkg::SET_COUNT_RST;
      ways_in_use <= salfu_pkg::WAYS_IN_USE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        salfu_pkg::REG_BLOCK_BYTES: block_bytes <= pwdata[BW-1:0];
        salfu_pkg::REG_SET_COUNT:   set_count   <= pwdata[salfu_pkg::SETS_W-1:0];
        salfu_pkg::REG_WAYS_IN_USE: ways_in_use <= pwdata[WW-1:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    unique case (paddr[3:2])
      salfu_pkg::REG_BLOCK_BYTES: prdata = 32'(block_bytes);
      salfu_pkg::REG_SET_COUNT:   prdata = 32'(set_count);
      salfu_pkg::REG_WAYS_IN_USE: prdata = 32'(ways_in_use);
      default:                    prdata = '0;
    endcase
  end

  // Clamp geometry
  logic [BW-1:0] blk_eff;
  logic [BW-1:0] sets_eff;
  logic [WC-1:0] ways_eff;

  always_comb begin
    blk_eff = (block_bytes == '0) ? BW'(1) : block_bytes;
    if (set_count == '0) begin
      sets_eff = BW'(1);
    end else if (32'(set_count) > MAX_SETS) begin
      sets_eff = BW'(MAX_SETS);
    end else begin
      sets_eff = BW'(set_count);
    end
    if (ways_in_use == '0) begin
      ways_eff = WC'(1);
    end else if (32'(ways_in_use) > MAX_WAYS) begin
      ways_eff = WC'(MAX_WAYS);
    end else begin
      ways_eff = WC'(ways_in_use);
    end
  end

  // Control and datapath registers
  logic [2:0]            state;
  logic [LW-1:0]         clr_idx;
  logic [AW-1:0]         dq;
  logic [BW-1:0]         rem;
  logic [BW-1:0]         divisor;
  logic [STW-1:0]        step;
  logic [BW-1:0]         sets_r;
  logic [WC-1:0]         ways_r;
  logic [AW-1:0]         tag_r;
  logic [SW-1:0]         set_r;
  logic [WC-1:0]         iw;
  logic                  pv;
  logic [WC-1:0]         pw;
  logic [COUNT_BITS-1:0] best;
  logic [WC-1:0]         victim;
  logic                  hit_r;
  logic [WC-1:0]         fin_way;
  logic [COUNT_BITS-1:0] fin_count;
  logic                  out_valid;
  logic                  out_hit;

  // One restoring division step
  logic [BW:0]   sh;
  logic          ge;
  logic [BW-1:0] rem_next;
  logic [AW-1:0] dq_next;

  always_comb begin
    sh       = {rem, dq[AW-1]};
    ge       = sh >= {1'b0, divisor};
    rem_next = ge ? BW'(sh - {1'b0, divisor}) : sh[BW-1:0];
    dq_next  = {dq[AW-2:0], ge};
  end

  // Line memory: {valid, tag, count}
  logic [EW-1:0] mem [LINES];
  logic [EW-1:0] rd_q;
  logic          mem_re;
  logic          mem_we;
  logic [LW-1:0] rd_addr;
  logic [LW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          fin_go;

  assign fin_go  = (state == ST_FIN) && (!out_valid || rsp.ready);
  assign mem_re  = (state == ST_SCAN) && (iw < ways_r);
  assign rd_addr = LW'(set_r) * LW'(MAX_WAYS) + LW'(iw);
  assign mem_we  = (state == ST_CLEAR) || fin_go;

  always_comb begin
    if (state == ST_CLEAR) begin
      wr_addr = clr_idx;
      wr_data = '0;
    end else begin
      wr_addr = LW'(set_r) * LW'(MAX_WAYS) + LW'(fin_way);
      wr_data = {1'b1, tag_r, fin_count};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Fields of the line just read
  logic                  rd_valid;
  logic [AW-1:0]         rd_tag;
  logic [COUNT_BITS-1:0] rd_count;
  logic                  rd_hit;
  logic                  rd_take;

  always_comb begin
    rd_valid = rd_q[EW-1];
    rd_tag   = rd_q[EW-2 -: AW];
    rd_count = rd_q[COUNT_BITS-1:0];
    rd_hit   = pv && rd_valid && (rd_tag == tag_r);
    rd_take  = (pw == '0) || (rd_count <= best);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      pv        <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + LW'(1);
          if (32'(clr_idx) == LINES - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            dq      <= req.address;
            divisor <= blk_eff;
            rem     <= '0;
            step    <= '0;
            sets_r  <= sets_eff;
            ways_r  <= ways_eff;
            state   <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          step <= step + STW'(1);
          if (step == '1) begin
            dq      <= dq_next;
            divisor <= sets_r;
            rem     <= '0;
            state   <= ST_DIV2;
          end else begin
            dq  <= dq_next;
            rem <= rem_next;
          end
        end
        ST_DIV2: begin
          dq   <= dq_next;
          rem  <= rem_next;
          step <= step + STW'(1);
          if (step == '1) begin
            tag_r <= dq_next;
            set_r <= rem_next[SW-1:0];
            iw    <= '0;
            pv    <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue the next way, check the one read last cycle
          pv <= mem_re;
          pw <= iw;
          if (mem_re) begin
            iw <= iw + WC'(1);
          end
          if (rd_hit) begin
            hit_r     <= 1'b1;
            fin_way   <= pw;
            fin_count <= (rd_count == '1) ? rd_count : rd_count + COUNT_BITS'(1);
            state     <= ST_FIN;
          end else if (pv) begin
            if (rd_take) begin
              best   <= rd_count;
              victim <= pw;
            end
            if (pw == ways_r - WC'(1)) begin
              hit_r     <= 1'b0;
              fin_way   <= rd_take ? pw : victim;
              fin_count <= '0;
              state     <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            out_hit <= hit_r;
            pv      <= 1'b0;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.hit   = out_hit;

  `SAL_ASSERT(a_accept_starts_div, (req.valid && req.ready) |=> (state == ST_DIV1), "accept did not start division")
  `SAL_ASSERT(a_scan_bound, (state == ST_SCAN) |-> (iw <= ways_r), "way scan ran past ways in use")
  `SAL_ASSERT(a_write_phase, mem_we |-> (state == ST_CLEAR || state == ST_FIN), "line write outside clear or write-back")
  `SAL_ASSERT(a_result_from_fin, $rose(out_valid) |-> ($past(state) == ST_FIN), "result raised outside write-back")

endmodule
